// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the extension list decoder RTL.
// Depends on nothing; included by the modules that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property at every rising clock edge outside of reset.
`define TLVD_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: check failed");
// Check a property at every rising clock edge, reset included.
`define TLVD_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("%m: check failed");
`else
`define TLVD_ASSERT(label, clk, rst_n, prop)
`define TLVD_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

// ===== rtl/core/tlvd_pkg.sv =====
// Package of the extension list decoder: field widths, codes and the command
// format passed from the parser to the result stage. Depends on nothing.
`default_nettype none

package tlvd_pkg;

    localparam int MAX_COUNT_DEF   = 16;
    localparam int MAX_BODY_DEF    = 256;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam int TYPE_W  = 16;
    localparam int LEN_W   = 9;
    localparam int SLOT_W  = 4;
    localparam int BYTE_W  = 8;
    localparam int INDEX_W = 8;
    localparam int HDR_BYTES = 4;

    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_BODY   = 2'd1,
        KIND_OK     = 2'd2,
        KIND_ERROR  = 2'd3
    } tlvd_kind_t;

    typedef enum logic [1:0] {
        ERR_NONE    = 2'd0,
        ERR_SHORT   = 2'd1,
        ERR_TRUNC   = 2'd2,
        ERR_OVERRUN = 2'd3
    } tlvd_err_t;

    // One parsed input beat: an optional header or body record and an
    // optional status that follows it.
    typedef struct packed {
        logic               rec_valid;
        logic               rec_body;
        logic [TYPE_W-1:0]  ext_type;
        logic [LEN_W-1:0]   ext_length;
        logic [SLOT_W-1:0]  ext_slot;
        logic [BYTE_W-1:0]  body_byte;
        logic [INDEX_W-1:0] body_index;
        logic               stat_valid;
        tlvd_err_t          error_code;
    } tlvd_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/core/tlvd_if.sv =====
// Handshake channels of the extension list decoder: the byte stream and the
// result stream. Depends on tlvd_pkg.
`default_nettype none

interface tlvd_byte_if
    import tlvd_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface tlvd_result_if
    import tlvd_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic [TYPE_W-1:0]  ext_type;
    logic [LEN_W-1:0]   ext_length;
    logic [SLOT_W-1:0]  ext_slot;
    logic [BYTE_W-1:0]  body_byte;
    logic [INDEX_W-1:0] body_index;
    logic [1:0]         error_code;
    logic               end_of_run;

    modport source (output valid, output kind, output ext_type, output ext_length,
                    output ext_slot, output body_byte, output body_index,
                    output error_code, output end_of_run, input ready);
    modport sink (input valid, input kind, input ext_type, input ext_length,
                  input ext_slot, input body_byte, input body_index,
                  input error_code, input end_of_run, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/tlvd_front.sv =====
// Parser of the extension list decoder: takes one byte per beat, tracks the
// list structure and emits one command per beat that yields results.
// Depends on tlvd_pkg, tlvd_if and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module tlvd_front
    import tlvd_pkg::*;
#(
    parameter int MAX_COUNT = MAX_COUNT_DEF,
    parameter int MAX_BODY  = MAX_BODY_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    tlvd_byte_if.sink  stream,
    input  wire logic  q_full,
    output logic       push,
    output tlvd_cmd_t  cmd
);

    localparam int KCW = $clog2(MAX_COUNT + 1);

    typedef enum logic [2:0] {
        PH_LEN_HI,
        PH_LEN_LO,
        PH_HDR,
        PH_BODY,
        PH_SKIP
    } phase_t;

    phase_t              phase_reg, phase_next;
    logic [15:0]         inner_len_reg, inner_len_next;
    logic [15:0]         inner_pos_reg, inner_pos_next;
    logic [31:0]         hdr_shift_reg, hdr_shift_next;
    logic [1:0]          hdr_cnt_reg, hdr_cnt_next;
    logic [15:0]         body_rem_reg, body_rem_next;
    logic [INDEX_W-1:0]  body_idx_reg, body_idx_next;
    logic                keep_reg, keep_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic [KCW-1:0]      kept_cnt_reg, kept_cnt_next;
    logic                overrun_reg, overrun_next;

    logic                fire;
    logic [7:0]          b;
    logic [31:0]         shift_in;
    logic [15:0]         pos_inc;
    logic [15:0]         room;
    logic [15:0]         hdr_len;
    logic [15:0]         full_len;
    logic                keep_hdr;

    assign stream.ready = !q_full;
    assign fire         = stream.valid && !q_full;
    assign b            = stream.data_byte;
    assign shift_in     = {hdr_shift_reg[23:0], b};
    assign pos_inc      = inner_pos_reg + 16'd1;
    assign room         = inner_len_reg - pos_inc;
    assign hdr_len      = shift_in[15:0];
    assign full_len     = {inner_len_reg[15:8], b};
    assign keep_hdr     = (hdr_len <= 16'(MAX_BODY)) && (kept_cnt_reg < KCW'(MAX_COUNT));

    always_comb
    begin
        phase_next     = phase_reg;
        inner_len_next = inner_len_reg;
        inner_pos_next = inner_pos_reg;
        hdr_shift_next = hdr_shift_reg;
        hdr_cnt_next   = hdr_cnt_reg;
        body_rem_next  = body_rem_reg;
        body_idx_next  = body_idx_reg;
        keep_next      = keep_reg;
        slot_next      = slot_reg;
        kept_cnt_next  = kept_cnt_reg;
        overrun_next   = overrun_reg;
        cmd            = '0;
        cmd.error_code = ERR_NONE;

        unique case (phase_reg)
            PH_LEN_HI:
            begin
                inner_len_next = {b, 8'h00};
                phase_next     = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                inner_len_next = full_len;
                inner_pos_next = '0;
                hdr_cnt_next   = '0;
                hdr_shift_next = '0;
                phase_next     = (full_len >= 16'(HDR_BYTES)) ? PH_HDR : PH_SKIP;
            end
            PH_HDR:
            begin
                inner_pos_next = pos_inc;
                hdr_shift_next = shift_in;
                hdr_cnt_next   = hdr_cnt_reg + 2'd1;
                if (hdr_cnt_reg == 2'(HDR_BYTES - 1))
                begin
                    if ({1'b0, pos_inc} + {1'b0, hdr_len} > {1'b0, inner_len_reg})
                    begin
                        overrun_next = 1'b1;
                        phase_next   = PH_SKIP;
                    end
                    else
                    begin
                        keep_next     = keep_hdr;
                        body_rem_next = hdr_len;
                        body_idx_next = '0;
                        if (keep_hdr)
                        begin
                            cmd.rec_valid  = 1'b1;
                            cmd.rec_body   = 1'b0;
                            cmd.ext_type   = shift_in[31:16];
                            cmd.ext_length = hdr_len[LEN_W-1:0];
                            cmd.ext_slot   = SLOT_W'(kept_cnt_reg);
                            slot_next      = SLOT_W'(kept_cnt_reg);
                            kept_cnt_next  = kept_cnt_reg + KCW'(1);
                        end
                        if (hdr_len != 16'd0)
                            phase_next = PH_BODY;
                        else
                        begin
                            hdr_shift_next = '0;
                            phase_next = (room >= 16'(HDR_BYTES)) ? PH_HDR : PH_SKIP;
                        end
                    end
                end
            end
            PH_BODY:
            begin
                inner_pos_next = pos_inc;
                body_rem_next  = body_rem_reg - 16'd1;
                body_idx_next  = body_idx_reg + INDEX_W'(1);
                if (keep_reg)
                begin
                    cmd.rec_valid  = 1'b1;
                    cmd.rec_body   = 1'b1;
                    cmd.ext_type   = hdr_shift_reg[31:16];
                    cmd.ext_length = hdr_shift_reg[LEN_W-1:0];
                    cmd.ext_slot   = slot_reg;
                    cmd.body_byte  = b;
                    cmd.body_index = body_idx_reg;
                end
                if (body_rem_reg == 16'd1)
                begin
                    hdr_cnt_next   = '0;
                    hdr_shift_next = '0;
                    phase_next = (room >= 16'(HDR_BYTES)) ? PH_HDR : PH_SKIP;
                end
            end
            PH_SKIP:
            begin
                if (inner_pos_reg < inner_len_reg)
                    inner_pos_next = pos_inc;
            end
            default:
            begin
                phase_next = PH_LEN_HI;
            end
        endcase

        if (stream.last_byte)
        begin
            cmd.stat_valid = 1'b1;
            priority if (phase_reg == PH_LEN_HI)
                cmd.error_code = ERR_SHORT;
            else if (inner_pos_next < inner_len_next)
                cmd.error_code = ERR_TRUNC;
            else if (overrun_next)
                cmd.error_code = ERR_OVERRUN;
            else
                cmd.error_code = ERR_NONE;

            // The buffer is done: start over for the next one.
            phase_next     = PH_LEN_HI;
            inner_len_next = '0;
            inner_pos_next = '0;
            hdr_shift_next = '0;
            hdr_cnt_next   = '0;
            body_rem_next  = '0;
            body_idx_next  = '0;
            keep_next      = 1'b0;
            kept_cnt_next  = '0;
            overrun_next   = 1'b0;
        end
    end

    assign push = fire && (cmd.rec_valid || cmd.stat_valid);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_LEN_HI;
            inner_len_reg <= '0;
            inner_pos_reg <= '0;
            hdr_shift_reg <= '0;
            hdr_cnt_reg   <= '0;
            body_rem_reg  <= '0;
            body_idx_reg  <= '0;
            keep_reg      <= 1'b0;
            slot_reg      <= '0;
            kept_cnt_reg  <= '0;
            overrun_reg   <= 1'b0;
        end
        else if (fire)
        begin
            phase_reg     <= phase_next;
            inner_len_reg <= inner_len_next;
            inner_pos_reg <= inner_pos_next;
            hdr_shift_reg <= hdr_shift_next;
            hdr_cnt_reg   <= hdr_cnt_next;
            body_rem_reg  <= body_rem_next;
            body_idx_reg  <= body_idx_next;
            keep_reg      <= keep_next;
            slot_reg      <= slot_next;
            kept_cnt_reg  <= kept_cnt_next;
            overrun_reg   <= overrun_next;
        end
    end

    // The kept counter saturates at the configured limit.
    `TLVD_ASSERT(a_kept_bound, clk, rst_n, kept_cnt_reg <= KCW'(MAX_COUNT))
    // Parsing never advances past the end of the declared inner region.
    `TLVD_ASSERT(a_pos_bound, clk, rst_n, inner_pos_reg <= inner_len_reg)
    // A body beat is only ever in flight while a body is being read.
    `TLVD_ASSERT(a_body_phase, clk, rst_n, (phase_reg == PH_BODY) |-> (body_rem_reg != 16'd0))

endmodule

`default_nettype wire

// ===== rtl/core/tlvd_queue.sv =====
// Short command queue between the parser and the result stage.
// Depends on tlvd_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module tlvd_queue
    import tlvd_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    input  wire tlvd_cmd_t  wr_cmd,
    input  wire logic       pop,
    output tlvd_cmd_t       head,
    output logic            full,
    output logic            empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    tlvd_cmd_t           slots [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]    count_reg;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = slots[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            slots[wr_ptr_reg] <= wr_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            if (push && !pop)
                count_reg <= count_reg + CNT_W'(1);
            else if (pop && !push)
                count_reg <= count_reg - CNT_W'(1);
        end
    end

    // Neither side may act on the queue in a state that forbids it.
    `TLVD_ASSERT(a_no_overflow, clk, rst_n, !(push && full))
    `TLVD_ASSERT(a_no_underflow, clk, rst_n, !(pop && empty))

endmodule

`default_nettype wire

// ===== rtl/core/tlvd_back.sv =====
// Result stage of the extension list decoder: expands each queued command into
// one or two result beats held in an output register.
// Depends on tlvd_pkg, tlvd_if and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module tlvd_back
    import tlvd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire tlvd_cmd_t   head,
    input  wire logic        empty,
    output logic             pop,
    tlvd_result_if.source    results
);

    logic                out_valid_reg;
    tlvd_kind_t          kind_reg, kind_next;
    logic [TYPE_W-1:0]   type_reg, type_next;
    logic [LEN_W-1:0]    length_reg, length_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic [BYTE_W-1:0]   byte_reg, byte_next;
    logic [INDEX_W-1:0]  index_reg, index_next;
    tlvd_err_t           err_reg, err_next;
    logic                eor_reg, eor_next;
    logic                second_reg, second_next;
    logic                load;
    logic                take;
    logic                emit_rec;

    assign load     = !out_valid_reg || results.ready;
    assign take     = load && !empty;
    assign emit_rec = head.rec_valid && !second_reg;

    always_comb
    begin
        kind_next   = KIND_OK;
        type_next   = '0;
        length_next = '0;
        slot_next   = '0;
        byte_next   = '0;
        index_next  = '0;
        err_next    = ERR_NONE;
        eor_next    = 1'b1;
        second_next = second_reg;
        pop         = 1'b0;
        if (emit_rec)
        begin
            kind_next   = head.rec_body ? KIND_BODY : KIND_HEADER;
            type_next   = head.ext_type;
            length_next = head.ext_length;
            slot_next   = head.ext_slot;
            byte_next   = head.body_byte;
            index_next  = head.body_index;
            eor_next    = !head.stat_valid;
            if (take)
            begin
                second_next = head.stat_valid;
                pop         = !head.stat_valid;
            end
        end
        else
        begin
            kind_next = (head.error_code == ERR_NONE) ? KIND_OK : KIND_ERROR;
            err_next  = head.error_code;
            if (take)
            begin
                second_next = 1'b0;
                pop         = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            second_reg    <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= !empty;
            second_reg    <= second_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            kind_reg   <= kind_next;
            type_reg   <= type_next;
            length_reg <= length_next;
            slot_reg   <= slot_next;
            byte_reg   <= byte_next;
            index_reg  <= index_next;
            err_reg    <= err_next;
            eor_reg    <= eor_next;
        end
    end

    assign results.valid      = out_valid_reg;
    assign results.kind       = kind_reg;
    assign results.ext_type   = type_reg;
    assign results.ext_length = length_reg;
    assign results.ext_slot   = slot_reg;
    assign results.body_byte  = byte_reg;
    assign results.body_index = index_reg;
    assign results.error_code = err_reg;
    assign results.end_of_run = eor_reg;

    // A pending status half always has its command still at the queue head.
    `TLVD_ASSERT(a_second_has_head, clk, rst_n, second_reg |-> !empty)
    // A status beat always closes the run of its input beat.
    `TLVD_ASSERT(a_status_ends, clk, rst_n, (out_valid_reg && (kind_reg == KIND_OK || kind_reg == KIND_ERROR)) |-> eor_reg)

endmodule

`default_nettype wire

// ===== rtl/core/tlv_extension_list_decoder.sv =====
// A result beat passes through the command queue, then the output register.
// Throughput: one byte per cycle while the queue has room; results leave at
// one per cycle while the receiver is ready, so a byte that yields a header or
// body result and a status takes two output beats, absorbed by the queue.
// Reset: rst_n is asynchronous, active low; it empties the queue and the
// output register and returns the parser to the first length byte.
`default_nettype none

module tlv_extension_list_decoder
    import tlvd_pkg::*;
#(
    parameter int MAX_COUNT   = MAX_COUNT_DEF,
    parameter int MAX_BODY    = MAX_BODY_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    tlvd_byte_if.sink      stream,
    tlvd_result_if.source  results
);

    // The parser turns each accepted byte into at most one command. Bytes
    // of the length prefix, of skipped extensions and past the inner region
    // produce no command unless they are the last byte of the buffer.
    tlvd_cmd_t  wr_cmd;
    tlvd_cmd_t  head;
    logic       push;
    logic       pop;
    logic       q_full;
    logic       q_empty;

    tlvd_front #(
        .MAX_COUNT (MAX_COUNT),
        .MAX_BODY  (MAX_BODY)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .stream (stream),
        .q_full (q_full),
        .push   (push),
        .cmd    (wr_cmd)
    );

    // The queue lets the parser keep taking bytes while the output side is
    // stalled or busy with the second beat of a two-result command.
    tlvd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wr_cmd (wr_cmd),
        .pop    (pop),
        .head   (head),
        .full   (q_full),
        .empty  (q_empty)
    );

    // The result stage emits the record first and the status second, with
    // end_of_run on the final beat for each input byte.
    tlvd_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .head    (head),
        .empty   (q_empty),
        .pop     (pop),
        .results (results)
    );

endmodule

`default_nettype wire
